// ===== rtl/core/tqc_pkg.sv =====
// ----------------------------------------------------------------------------
// tqc_pkg
// Shared types and constants of the three-point quadratic turbidity
// calibration block.
// ----------------------------------------------------------------------------
package tqc_pkg;

    // Register map of the configuration port, by word index.
    typedef enum logic [2:0] {
        REG_VOLT_CLEAR = 3'd0,
        REG_VOLT_MID   = 3'd1,
        REG_VOLT_MURKY = 3'd2,
        REG_NTU_CLEAR  = 3'd3,
        REG_NTU_MID    = 3'd4,
        REG_NTU_MURKY  = 3'd5
    } t_reg_idx;

    // Width of one turbidity value and of a signed difference of two.
    localparam int NTU_BITS = 16;
    localparam int DY_BITS  = NTU_BITS + 1;

    // Operand slice of the split multiplier.
    localparam int MUL_CHUNK = 16;

    // Quotient bits resolved by the divider; a larger quotient saturates.
    localparam int QUO_BITS = 16;

    // Saturation limits of the result.
    localparam logic signed [NTU_BITS-1:0] SAT_POS = 16'sh7FFF;
    localparam logic signed [NTU_BITS-1:0] SAT_NEG = 16'sh8000;

    // Flags that travel with an item through the divider.
    typedef struct packed {
        logic clamp;
        logic inv;
        logic neg;
    } t_flags;

endpackage

// ===== rtl/core/tqc_mul.sv =====
// ----------------------------------------------------------------------------
// tqc_mul
// Two-stage signed multiplier. The second operand is cut into slices; each
// slice product is registered, and the shifted slice products are summed
// into the registered result.
// ----------------------------------------------------------------------------
module tqc_mul
    import tqc_pkg::*;
#(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [WA-1:0]    i_a,
    input  logic signed [WB-1:0]    i_b,
    output logic signed [WA+WB-1:0] o_p
);

    localparam int NC = (WB + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int BX = NC * MUL_CHUNK;
    localparam int PW = WA + MUL_CHUNK + 1;
    localparam int WP = WA + WB;

    logic signed [BX-1:0] bx;
    logic signed [PW-1:0] r_pp [NC];
    logic signed [WP-1:0] n_p;
    logic signed [WP-1:0] r_p;

    assign bx = BX'(i_b);

    // Slice products; all slices are unsigned but the top one.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NC; k++) begin
                if (k == NC - 1) begin
                    r_pp[k] <= i_a * $signed(bx[k*MUL_CHUNK +: MUL_CHUNK]);
                end else begin
                    r_pp[k] <= i_a * $signed({1'b0, bx[k*MUL_CHUNK +: MUL_CHUNK]});
                end
            end
        end
    end

    // Weighted sum of the slice products.
    always_comb begin
        n_p = '0;
        for (int k = 0; k < NC; k++) begin
            n_p = n_p + (WP'(r_pp[k]) <<< (k * MUL_CHUNK));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

// ===== rtl/core/tqc_div.sv =====
// ----------------------------------------------------------------------------
// tqc_div
// Pipelined restoring divider. The first stage flags a quotient too large
// for the result; each following stage resolves one quotient bit, most
// significant first.
// ----------------------------------------------------------------------------
module tqc_div
    import tqc_pkg::*;
#(
    parameter int RW = 96
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [RW-1:0]       i_num,
    input  logic [RW-1:0]       i_den,
    output logic [QUO_BITS-1:0] o_quo,
    output logic                o_ovf
);

    localparam int NS = QUO_BITS + 1;

    logic [RW-1:0]       r_rem [NS];
    logic [RW-1:0]       r_den [NS];
    logic [QUO_BITS-1:0] r_quo [NS];
    logic                r_ovf [NS];

    // Range stage: a quotient of 2^QUO_BITS or more saturates.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_ovf[0] <= (i_num >= (i_den << QUO_BITS));
        end
    end

    // One quotient bit per stage.
    for (genvar s = 1; s < NS; s++) begin : g_step
        localparam int BIT = QUO_BITS - s;
        logic [RW-1:0] shd;
        logic          ge;

        assign shd = r_den[s-1] << BIT;
        assign ge  = (r_rem[s-1] >= shd);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= ge ? (r_rem[s-1] - shd) : r_rem[s-1];
                r_den[s] <= r_den[s-1];
                r_ovf[s] <= r_ovf[s-1];
                r_quo[s] <= r_quo[s-1] | (QUO_BITS'(ge) << BIT);
            end
        end
    end

    assign o_quo = r_quo[NS-1];
    assign o_ovf = r_ovf[NS-1];

endmodule

// ===== rtl/core/turbidity_quadratic_calibration_top.sv =====
// ----------------------------------------------------------------------------
// turbidity_quadratic_calibration_top
// Evaluates the parabola through three calibration points at a sample
// voltage, clamping to the vertex value below the vertex, and returns the
// result in tenths of NTU, saturated to signed 16 bits.
//
//   Channel   Direction  Handshake            Payload
//   input     in         i_valid / o_stall    i_sample_mv
//   output    out        o_valid / i_stall    o_turbidity_tenths, o_clamped,
//                                             o_invalid
//   config    in         APB write/read       six calibration registers
//
// One beat enters per cycle while o_stall is low; results leave in the order of their input beats.
// The 17-stage divider and the split wide multipliers set the depth.
// A stalled output freezes every stage at once, so nothing is lost or repeated.
// Reset clears the valid bits and loads the default calibration points.
// ----------------------------------------------------------------------------
module turbidity_quadratic_calibration_top
    import tqc_pkg::*;
#(
    parameter int VOLT_BITS = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [VOLT_BITS-1:0]        i_sample_mv,
    // output channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [NTU_BITS-1:0]  o_turbidity_tenths,
    output logic                        o_clamped,
    output logic                        o_invalid,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [4:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    // Arithmetic widths.
    localparam int VB   = VOLT_BITS;
    localparam int PW   = VB + 1;
    localparam int YW   = DY_BITS;
    localparam int AW   = YW + PW + 1;
    localparam int BW   = YW + 2 * PW + 1;
    localparam int EW   = 3 * PW + 1;
    localparam int UUW  = 2 * PW;
    localparam int TW   = YW + 2 * PW + 3;
    localparam int DENW = AW + EW + 2;
    localparam int NC1  = DENW + YW;
    localparam int NC2  = 2 * BW;
    localparam int NN1  = AW + UUW;
    localparam int NN2  = BW + PW;
    localparam int NN3  = EW + YW;
    localparam int MC   = (NC1 > NC2) ? NC1 : NC2;
    localparam int MN0  = (NN1 > NN2) ? NN1 : NN2;
    localparam int MN   = (MN0 > NN3) ? MN0 : NN3;
    localparam int NS   = ((MC > MN) ? MC : MN) + 2;
    localparam int RW   = NS + 3;
    localparam int DLAT = QUO_BITS + 1;
    localparam int NST  = 9 + DLAT;

    logic adv;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [VB-1:0]       r_volt_clear, r_volt_mid, r_volt_murky;
    logic [NTU_BITS-1:0] r_ntu_clear, r_ntu_mid, r_ntu_murky;
    logic                cfg_wr;
    t_reg_idx            cfg_idx;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volt_clear <= VB'(2900);
            r_volt_mid   <= VB'(2700);
            r_volt_murky <= VB'(2500);
            r_ntu_clear  <= NTU_BITS'(0);
            r_ntu_mid    <= NTU_BITS'(3045);
            r_ntu_murky  <= NTU_BITS'(5115);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_VOLT_CLEAR: r_volt_clear <= pwdata[VB-1:0];
                REG_VOLT_MID:   r_volt_mid   <= pwdata[VB-1:0];
                REG_VOLT_MURKY: r_volt_murky <= pwdata[VB-1:0];
                REG_NTU_CLEAR:  r_ntu_clear  <= pwdata[NTU_BITS-1:0];
                REG_NTU_MID:    r_ntu_mid    <= pwdata[NTU_BITS-1:0];
                REG_NTU_MURKY:  r_ntu_murky  <= pwdata[NTU_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (cfg_idx)
            REG_VOLT_CLEAR: prdata = 32'(r_volt_clear);
            REG_VOLT_MID:   prdata = 32'(r_volt_mid);
            REG_VOLT_MURKY: prdata = 32'(r_volt_murky);
            REG_NTU_CLEAR:  prdata = 32'(r_ntu_clear);
            REG_NTU_MID:    prdata = 32'(r_ntu_mid);
            REG_NTU_MURKY:  prdata = 32'(r_ntu_murky);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control: the whole pipeline advances unless a result is held.
    // ------------------------------------------------------------------
    logic r_out_vld;
    logic r_vld [NST];

    assign adv     = !(r_out_vld && i_stall);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < NST; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_vld <= r_vld[NST-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: offsets from the murky point and first products.
    // ------------------------------------------------------------------
    logic signed [PW-1:0] p, q, u;
    logic signed [YW-1:0] dy2, dy3, y1;

    assign p   = $signed({1'b0, r_volt_mid})   - $signed({1'b0, r_volt_murky});
    assign q   = $signed({1'b0, r_volt_clear}) - $signed({1'b0, r_volt_murky});
    assign u   = $signed({1'b0, i_sample_mv})  - $signed({1'b0, r_volt_murky});
    assign y1  = $signed({1'b0, r_ntu_murky});
    assign dy2 = $signed({1'b0, r_ntu_mid})   - y1;
    assign dy3 = $signed({1'b0, r_ntu_clear}) - y1;

    logic signed [YW+PW-1:0] r1_dy3p, r1_dy2q;
    logic signed [PW-1:0]    r1_p, r1_q, r1_u;
    logic signed [2*PW-1:0]  r1_pq;
    logic signed [PW:0]      r1_qmp;
    logic signed [UUW-1:0]   r1_uu;
    logic signed [YW-1:0]    r1_y1;
    logic                    r1_inv;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_dy3p <= dy3 * p;
            r1_dy2q <= dy2 * q;
            r1_p    <= p;
            r1_q    <= q;
            r1_pq   <= p * q;
            r1_qmp  <= q - p;
            r1_u    <= u;
            r1_uu   <= u * u;
            r1_y1   <= y1;
            r1_inv  <= (p == '0) || (q == '0) || (p == q);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: fit coefficients An, Bn and E.
    // ------------------------------------------------------------------
    logic signed [YW+2*PW-1:0] bq, bp;
    logic signed [AW-1:0]      r2_an;
    logic signed [BW-1:0]      r2_bn;
    logic signed [EW-1:0]      r2_e;
    logic signed [PW-1:0]      r2_u;
    logic signed [UUW-1:0]     r2_uu;
    logic signed [YW-1:0]      r2_y1;
    logic                      r2_inv;

    assign bq = r1_dy2q * r1_q;
    assign bp = r1_dy3p * r1_p;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_an  <= r1_dy3p - r1_dy2q;
            r2_bn  <= bq - bp;
            r2_e   <= r1_pq * r1_qmp;
            r2_u   <= r1_u;
            r2_uu  <= r1_uu;
            r2_y1  <= r1_y1;
            r2_inv <= r1_inv;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: vertex test and the terms of the direct evaluation.
    // Bn*Bn and An*E go through the split multipliers.
    // ------------------------------------------------------------------
    logic signed [TW-1:0]     t;
    logic signed [NN1-1:0]    r3_anuu;
    logic signed [NN2-1:0]    r3_bnu;
    logic signed [NN3-1:0]    r3_y1e;
    logic signed [EW-1:0]     r3_e;
    logic signed [YW-1:0]     r3_y1;
    logic                     r3_clamp, r3_inv;
    logic signed [NC2-1:0]    bnbn;
    logic signed [AW+EW-1:0]  ane;

    assign t = 2 * r2_an * r2_u + r2_bn;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_anuu  <= r2_an * r2_uu;
            r3_bnu   <= r2_bn * r2_u;
            r3_y1e   <= r2_y1 * r2_e;
            r3_e     <= r2_e;
            r3_y1    <= r2_y1;
            r3_clamp <= (r2_an != '0) &&
                        (((r2_an > 0) && (t < 0)) || ((r2_an < 0) && (t > 0)));
            r3_inv   <= r2_inv;
        end
    end

    tqc_mul #(.WA(BW), .WB(BW)) u_mul_bnbn (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (r2_bn),
        .i_b   (r2_bn),
        .o_p   (bnbn)
    );

    tqc_mul #(.WA(EW), .WB(AW)) u_mul_ane (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (r2_e),
        .i_b   (r2_an),
        .o_p   (ane)
    );

    // ------------------------------------------------------------------
    // Stage 4: direct numerator; 4*An*E times y1 goes to the third
    // multiplier.
    // ------------------------------------------------------------------
    logic signed [NS-1:0]   r4_nn;
    logic signed [EW-1:0]   r4_e;
    logic signed [YW-1:0]   r4_y1;
    logic                   r4_clamp, r4_inv;
    logic signed [DENW-1:0] den4;
    logic signed [NC1-1:0]  deny1;

    assign den4 = DENW'(ane) <<< 2;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_nn    <= NS'(r3_anuu) + NS'(r3_bnu) + NS'(r3_y1e);
            r4_e     <= r3_e;
            r4_y1    <= r3_y1;
            r4_clamp <= r3_clamp;
            r4_inv   <= r3_inv;
        end
    end

    tqc_mul #(.WA(DENW), .WB(YW)) u_mul_deny1 (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (den4),
        .i_b   (r4_y1),
        .o_p   (deny1)
    );

    // ------------------------------------------------------------------
    // Stages 5 and 6: hold the operands until the third product is ready.
    // ------------------------------------------------------------------
    logic signed [DENW-1:0] r5_den, r6_den;
    logic signed [NC2-1:0]  r5_bnbn, r6_bnbn;
    logic signed [NS-1:0]   r5_nn, r6_nn;
    logic signed [EW-1:0]   r5_e, r6_e;
    logic                   r5_clamp, r6_clamp, r5_inv, r6_inv;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_den   <= den4;
            r5_bnbn  <= bnbn;
            r5_nn    <= r4_nn;
            r5_e     <= r4_e;
            r5_clamp <= r4_clamp;
            r5_inv   <= r4_inv;
            r6_den   <= r5_den;
            r6_bnbn  <= r5_bnbn;
            r6_nn    <= r5_nn;
            r6_e     <= r5_e;
            r6_clamp <= r5_clamp;
            r6_inv   <= r5_inv;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: pick the numerator and denominator of the chosen branch.
    // ------------------------------------------------------------------
    logic signed [NS-1:0] r7_num, r7_den;
    logic                 r7_clamp, r7_inv;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r6_clamp) begin
                r7_num <= NS'(deny1) - NS'(r6_bnbn);
                r7_den <= NS'(r6_den);
            end else begin
                r7_num <= r6_nn;
                r7_den <= NS'(r6_e);
            end
            r7_clamp <= r6_clamp;
            r7_inv   <= r6_inv;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: magnitudes and result sign.
    // ------------------------------------------------------------------
    logic [NS-1:0] r8_nmag, r8_dmag;
    t_flags        r8_flg;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r8_nmag      <= (r7_num < 0) ? NS'(-r7_num) : NS'(r7_num);
            r8_dmag      <= (r7_den < 0) ? NS'(-r7_den) : NS'(r7_den);
            r8_flg.neg   <= (r7_num != '0) && ((r7_num < 0) != (r7_den < 0));
            r8_flg.clamp <= r7_clamp;
            r8_flg.inv   <= r7_inv;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: rounding offset, (2n + d) / 2d.
    // ------------------------------------------------------------------
    logic [RW-1:0] r9_n2, r9_d2;
    t_flags        r9_flg;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r9_n2  <= (RW'(r8_nmag) << 1) + RW'(r8_dmag);
            r9_d2  <= RW'(r8_dmag) << 1;
            r9_flg <= r8_flg;
        end
    end

    // ------------------------------------------------------------------
    // Divider, with the flags riding alongside.
    // ------------------------------------------------------------------
    logic [QUO_BITS-1:0] quo;
    logic                ovf;
    t_flags              r_flg [DLAT];

    tqc_div #(.RW(RW)) u_div (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r9_n2),
        .i_den (r9_d2),
        .o_quo (quo),
        .o_ovf (ovf)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_flg[0] <= r9_flg;
            for (int k = 1; k < DLAT; k++) begin
                r_flg[k] <= r_flg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: sign, saturation and the invalid override.
    // ------------------------------------------------------------------
    t_flags                      fo;
    logic signed [NTU_BITS-1:0]  n_res;
    logic signed [NTU_BITS-1:0]  r_res;
    logic                        r_clamped, r_invalid;

    assign fo = r_flg[DLAT-1];

    always_comb begin
        if (fo.inv) begin
            n_res = '0;
        end else if (fo.neg) begin
            if (ovf || (quo > 16'd32768)) begin
                n_res = SAT_NEG;
            end else begin
                n_res = NTU_BITS'(-$signed({1'b0, quo}));
            end
        end else begin
            if (ovf || (quo > 16'd32767)) begin
                n_res = SAT_POS;
            end else begin
                n_res = $signed(quo);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res     <= n_res;
            r_clamped <= fo.clamp && !fo.inv;
            r_invalid <= fo.inv;
        end
    end

    assign o_valid            = r_out_vld;
    assign o_turbidity_tenths = r_res;
    assign o_clamped          = r_clamped;
    assign o_invalid          = r_invalid;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // An invalid calibration gives a zero, unclamped result.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_invalid) |-> ((o_turbidity_tenths == '0) && !o_clamped))
        else $error("invalid result is not zero and unclamped");

    // The input side only backs up behind a held result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result waiting");

    // A held result keeps its flags while the pipeline is frozen.
    a_hold_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(o_clamped) && $stable(o_invalid)))
        else $error("result flags changed under stall");

endmodule

// ===== test/turbidity_quadratic_calibration_top_test.sv =====
// ----------------------------------------------------------------------------
// turbidity_quadratic_calibration_top_test
// Self-checking regression of the quadratic turbidity calibration block.
// A scoreboard class predicts each result from the accepted sample beats and
// its own copy of the calibration registers, and checks the output beats in
// order. Directed beats cover the corner cases. Random phases follow, each with
// a fresh calibration and one of four idle and stall patterns.
// ----------------------------------------------------------------------------
module turbidity_quadratic_calibration_top_test
    import tqc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int        CYCLE_LIMIT   = 400000;
    localparam int        DRAIN_CYCLES  = 40;
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    typedef logic signed [127:0] t_wide;

    // One expected output beat.
    typedef struct {
        logic signed [15:0] tenths;
        logic               clamped;
        logic               invalid;
    } t_reading;

    // Calibration model and queue of pending readings.
    class turbidity_scoreboard;
        logic [15:0] cal [6];
        t_reading    pending_q [$];
        int          errors;

        function new();
            errors = 0;
            cal[REG_VOLT_CLEAR] = 2900;
            cal[REG_VOLT_MID]   = 2700;
            cal[REG_VOLT_MURKY] = 2500;
            cal[REG_NTU_CLEAR]  = 0;
            cal[REG_NTU_MID]    = 3045;
            cal[REG_NTU_MURKY]  = 5115;
        endfunction

        function void write_cal(logic [2:0] idx, logic [31:0] value);
            if (idx <= REG_VOLT_MURKY) begin
                cal[idx] = {4'd0, value[11:0]};
            end else if (idx <= REG_NTU_MURKY) begin
                cal[idx] = value[15:0];
            end
        endfunction

        // Division rounded half away from zero, saturated to 16 bits signed.
        function logic signed [15:0] round_sat(t_wide num, t_wide den);
            logic        neg;
            logic [127:0] mag;
            logic [127:0] quo;
            if (den < 0) begin
                den = -den;
                num = -num;
            end
            neg = num < 0;
            mag = neg ? -num : num;
            quo = (2 * mag + den) / (2 * den);
            if (neg) begin
                return (quo > 128'd32768) ? SAT_NEG : -$signed(quo[16:0]);
            end
            return (quo > 128'd32767) ? SAT_POS : quo[15:0];
        endfunction

        function t_reading predict_reading(logic [11:0] sample);
            longint   x1, y1, p, q, dy2, dy3, an, bn, e, u, slope;
            t_wide    num, den;
            t_reading r;
            x1  = cal[REG_VOLT_MURKY];
            y1  = cal[REG_NTU_MURKY];
            p   = longint'(cal[REG_VOLT_MID]) - x1;
            q   = longint'(cal[REG_VOLT_CLEAR]) - x1;
            dy2 = longint'(cal[REG_NTU_MID]) - y1;
            dy3 = longint'(cal[REG_NTU_CLEAR]) - y1;
            r.clamped = 1'b0;
            r.invalid = 1'b0;
            r.tenths  = '0;
            if (p == 0 || q == 0 || p == q) begin
                r.invalid = 1'b1;
                return r;
            end
            an = dy3 * p - dy2 * q;
            bn = dy2 * q * q - dy3 * p * p;
            e  = p * q * (q - p);
            u  = longint'(sample) - x1;
            // Below the vertex the slope has the opposite sign of the curvature.
            if (an != 0) begin
                slope = 2 * an * u + bn;
                r.clamped = (an > 0 && slope < 0) || (an < 0 && slope > 0);
            end
            if (r.clamped) begin
                den = 4 * t_wide'(an) * t_wide'(e);
                num = den * t_wide'(y1) - t_wide'(bn) * t_wide'(bn);
            end else begin
                den = t_wide'(e);
                num = t_wide'(an) * t_wide'(u * u) + t_wide'(bn) * t_wide'(u)
                    + t_wide'(y1) * t_wide'(e);
            end
            r.tenths = round_sat(num, den);
            return r;
        endfunction

        function void note_sample(logic [11:0] sample);
            pending_q.push_back(predict_reading(sample));
        endfunction

        function void check_reading(logic signed [15:0] tenths, logic clamped,
                                    logic invalid);
            t_reading exp_r;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected beat: tenths %0d clamped %0b invalid %0b",
                         $time, tenths, clamped, invalid);
                errors++;
                return;
            end
            exp_r = pending_q.pop_front();
            if (tenths !== exp_r.tenths) begin
                $display("%0t: tenths mismatch: expected %0d actual %0d",
                         $time, exp_r.tenths, tenths);
                errors++;
            end
            if (clamped !== exp_r.clamped) begin
                $display("%0t: clamped mismatch: expected %0b actual %0b",
                         $time, exp_r.clamped, clamped);
                errors++;
            end
            if (invalid !== exp_r.invalid) begin
                $display("%0t: invalid mismatch: expected %0b actual %0b",
                         $time, exp_r.invalid, invalid);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [11:0]        i_sample_mv;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_turbidity_tenths;
    logic               o_clamped;
    logic               o_invalid;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    turbidity_scoreboard sb;
    int                  idle_pct;
    int                  stall_pct;
    int                  cycles;

    turbidity_quadratic_calibration_top dut (.*);

    // Clock and run limit.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("turbidity_quadratic_calibration_top regression: fail");
                $finish;
            end
        end
    end

    // Receiver stalls at random.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Check each output beat.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_reading(o_turbidity_tenths, o_clamped, o_invalid);
        end
    end

    // APB write, then for a calibration register read back what it should hold.
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.write_cal(idx, value);
        if (idx <= REG_NTU_MURKY) begin
            @(negedge i_clk);
            psel   <= 1'b1;
            pwrite <= 1'b0;
            @(negedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            if (prdata[15:0] !== sb.cal[idx]) begin
                $display("%0t: register %0d readback: expected %0d actual %0d",
                         $time, idx, sb.cal[idx], prdata[15:0]);
                sb.errors++;
            end
            @(negedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    // Upper data bits carry junk now and then; the block must drop them.
    task automatic set_cal(int vc, int vm, int vk, int nc, int nm, int nk);
        logic [31:0] junk;
        junk = $urandom_range(3) == 0 ? ($urandom() & 32'hFFFF0000) : 32'd0;
        write_reg(REG_VOLT_CLEAR, junk | (vc & 32'hFFF) | ($urandom_range(1) << 12));
        write_reg(REG_VOLT_MID,   junk | (vm & 32'hFFF));
        write_reg(REG_VOLT_MURKY, junk | (vk & 32'hFFF));
        write_reg(REG_NTU_CLEAR,  junk | (nc & 32'hFFFF));
        write_reg(REG_NTU_MID,    junk | (nm & 32'hFFFF));
        write_reg(REG_NTU_MURKY,  junk | (nk & 32'hFFFF));
    endtask

    task automatic random_cal();
        int kind, x, d, y, k;
        kind = $urandom_range(9);
        if (kind == 0) begin
            // Two equal calibration voltages.
            x = $urandom_range(4095);
            set_cal(x, $urandom_range(1) ? x : $urandom_range(4095), x,
                    $urandom(), $urandom(), $urandom());
        end else if (kind == 1) begin
            // Evenly spaced, collinear points give zero curvature.
            d = $urandom_range(1, 1300);
            x = $urandom_range(4095 - 2 * d);
            k = $urandom_range(20000);
            y = $urandom_range(65535 - 2 * k);
            set_cal(x + 2 * d, x + d, x, y + 2 * k, y + k, y);
        end else begin
            set_cal($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                    $urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
        end
        if ($urandom_range(3) == 0) begin
            write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
        end
    endtask

    // Send one sample beat, with random idle cycles ahead of it.
    task automatic send_sample(logic [11:0] sample);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            i_sample_mv <= 12'($urandom());
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_sample_mv <= sample;
        do @(posedge i_clk); while (o_stall);
        sb.note_sample(sample);
    endtask

    // Wait until every reading is back and the pipeline has emptied.
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [11:0] random_sample();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return 12'd0;
        if (pick == 1) return 12'hFFF;
        if (pick < 5) begin
            return 12'(sb.cal[REG_VOLT_MURKY][11:0] + $urandom_range(600) - 300);
        end
        return 12'($urandom());
    endfunction

    initial begin
        sb          = new();
        idle_pct    = 0;
        stall_pct   = 0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_stall     = 1'b0;
        i_sample_mv = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default calibration: both sides of the vertex and the field extremes.
        send_sample(12'd0);
        send_sample(12'hFFF);
        send_sample(12'd2500);
        send_sample(12'd2700);
        send_sample(12'd2900);
        send_sample(12'd2048);
        drain();

        // Full-range points with extreme turbidity values.
        set_cal(4095, 2048, 0, 65535, 0, 65535);
        send_sample(12'd0);
        send_sample(12'hFFF);
        send_sample(12'd2048);
        send_sample(12'd1000);
        drain();

        // Downward parabola: the top sample saturates negative, the others saturate positive.
        set_cal(1200, 1100, 1000, 0, 65535, 0);
        send_sample(12'd0);
        send_sample(12'hFFF);
        send_sample(12'd1100);
        send_sample(12'd1120);
        drain();

        // Equal calibration voltages, then a straight line, then ignored spare writes.
        set_cal(3000, 3000, 1000, 100, 200, 300);
        send_sample(12'd1500);
        send_sample(12'd3000);
        drain();
        set_cal(3000, 2000, 1000, 300, 200, 100);
        write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_HI, 32'h0000_0123);
        send_sample(12'd0);
        send_sample(12'hFFF);
        send_sample(12'd1999);
        drain();

        // Random phases cycle through the idle and stall patterns.
        for (int phase = 0; phase < 20; phase++) begin
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 73; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 73; end
                default: begin idle_pct = 36; stall_pct = 36; end
            endcase
            random_cal();
            for (int n = 0; n < 27; n++) begin
                send_sample(random_sample());
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("turbidity_quadratic_calibration_top regression: pass");
        end else begin
            $display("turbidity_quadratic_calibration_top regression: fail");
        end
        $finish;
    end

endmodule
